// ----- design/gdet_pkg.sv -----
// Shared types and constants for the green blob detector.
package gdet_pkg;

    // Frame size limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 30;
    localparam int AREA_W     = 21;
    localparam int DEN_W      = 31;
    localparam int NUM_W      = 32;
    localparam int C50_W      = 27;
    localparam int RATIO_W    = 17;
    localparam int CX_W       = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // Shared divider: dividend, divisor/remainder and bit-counter widths
    localparam int DVD_W      = 47;
    localparam int DVS_W      = 31;
    localparam int DIV_CNT_W  = 6;

    // Frame job queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOMINANCE_MARGIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GREEN        = 8'd3;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd64;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd64;
    localparam logic [PIX_W-1:0] RST_MARGIN       = 8'd40;
    localparam logic [PIX_W-1:0] RST_MIN_GREEN    = 8'd80;

    localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'd65536;
    localparam logic [C50_W-CNT_W-1:0] DETECT_FACTOR = 6'd50;

    // Effective settings seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PIX_W-1:0] margin;
        logic [PIX_W-1:0] min_green;
    } cfg_t;

    // One finished frame handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } job_t;

endpackage

// ----- design/gdet_front.sv -----
// Front end: pixel classification, raster position and per-frame accumulation.
module gdet_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gdet_pkg::cfg_t                  cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gdet_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output gdet_pkg::job_t                  q_job
);

    logic [gdet_pkg::POS_W-1:0] col_reg;
    logic [gdet_pkg::POS_W-1:0] row_reg;
    logic [gdet_pkg::CNT_W-1:0] total_reg;
    logic [gdet_pkg::SUM_W-1:0] colsum_reg;

    logic [gdet_pkg::PIX_W-1:0] red, green, blue;
    logic                       accept, is_green, last_col, last_row, frame_end;
    logic [gdet_pkg::CNT_W-1:0] total_next;
    logic [gdet_pkg::SUM_W-1:0] colsum_next;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // exact compares, one bit of headroom for the margin sum
    assign is_green = ({1'b0, green} > ({1'b0, red} + {1'b0, cfg.margin}))
                   && ({1'b0, green} > ({1'b0, blue} + {1'b0, cfg.margin}))
                   && (green > cfg.min_green);

    assign last_col = {1'b0, col_reg} >= (cfg.width - gdet_pkg::DIM_W'(1));
    assign last_row = {1'b0, row_reg} >= (cfg.height - gdet_pkg::DIM_W'(1));
    assign frame_end = accept && last_col && last_row;

    assign total_next  = total_reg + gdet_pkg::CNT_W'(is_green);
    assign colsum_next = is_green ? colsum_reg + gdet_pkg::SUM_W'(col_reg) : colsum_reg;

    assign q_push = frame_end;
    assign q_job  = '{count: total_next, sum: colsum_next,
                      width: cfg.width, height: cfg.height};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            total_reg  <= '0;
            colsum_reg <= '0;
        end else if (accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + gdet_pkg::POS_W'(1);
            end else begin
                col_reg <= col_reg + gdet_pkg::POS_W'(1);
            end
            if (frame_end) begin
                total_reg  <= '0;
                colsum_reg <= '0;
            end else begin
                total_reg  <= total_next;
                colsum_reg <= colsum_next;
            end
        end
    end

endmodule

// ----- design/gdet_fifo.sv -----
// Short show-ahead queue of finished frame jobs between front and back.
module gdet_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  gdet_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output gdet_pkg::job_t pop_job,
    output logic           empty
);

    gdet_pkg::job_t                  mem_reg [gdet_pkg::FIFO_DEPTH];
    logic [gdet_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [gdet_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [gdet_pkg::FIFO_CNT_W-1:0] fill_reg;
    logic                            do_push, do_pop;

    assign full    = fill_reg == gdet_pkg::FIFO_CNT_W'(gdet_pkg::FIFO_DEPTH);
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + gdet_pkg::FIFO_PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + gdet_pkg::FIFO_PTR_W'(1);
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + gdet_pkg::FIFO_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - gdet_pkg::FIFO_CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/gdet_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by ratio and centroid.
module gdet_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gdet_pkg::DVD_W-1:0]  dividend,
    input  logic [gdet_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [gdet_pkg::DVD_W-1:0]  quotient,
    output logic                        rem_nonzero
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [gdet_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [gdet_pkg::DVS_W-1:0]      rem_reg;
    logic [gdet_pkg::DVD_W-1:0]      quo_reg;
    logic [gdet_pkg::DVS_W-1:0]      dvs_reg;
    logic [gdet_pkg::DVS_W:0]        trial;
    logic                            fits;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[gdet_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = rem_reg != '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= gdet_pkg::DIV_CNT_W'(gdet_pkg::DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - gdet_pkg::DIV_CNT_W'(1);
                if (cnt_reg == gdet_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? gdet_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : gdet_pkg::DVS_W'(trial);
            quo_reg <= {quo_reg[gdet_pkg::DVD_W-2:0], fits};
        end
    end

endmodule

// ----- design/gdet_back.sv -----
// Back end: per-frame statistics sequencer and output register.
module gdet_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  gdet_pkg::job_t                   q_job,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gdet_pkg::OUT_DATA_W-1:0]  m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_AREA, ST_PROD, ST_NUM, ST_RATIO, ST_RATIO_WAIT,
        ST_CX, ST_CX_WAIT, ST_OUT
    } state_t;

    state_t                          state_reg;
    gdet_pkg::job_t                  job_reg;
    logic [gdet_pkg::AREA_W-1:0]     area_reg;
    logic [gdet_pkg::DEN_W-1:0]      den_reg;
    logic [gdet_pkg::C50_W-1:0]      c50_reg;
    logic signed [gdet_pkg::NUM_W-1:0] num_reg;
    logic [gdet_pkg::RATIO_W-1:0]    ratio_reg;
    logic [gdet_pkg::CX_W-1:0]       cx_reg;
    logic                            div_start_reg;
    logic [gdet_pkg::DVD_W-1:0]      div_dvd_reg;
    logic [gdet_pkg::DVS_W-1:0]      div_dvs_reg;
    logic                            out_valid_reg;
    logic [gdet_pkg::CNT_W-1:0]      out_count_reg;
    logic                            out_detect_reg;
    logic [gdet_pkg::RATIO_W-1:0]    out_ratio_reg;
    logic [gdet_pkg::CX_W-1:0]       out_cx_reg;

    logic                            div_done, div_rem_nz;
    logic [gdet_pkg::DVD_W-1:0]      div_quo;
    logic [gdet_pkg::DVS_W-1:0]      num_mag;
    logic [gdet_pkg::CX_W:0]         neg_q;

    gdet_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start_reg),
        .dividend    (div_dvd_reg),
        .divisor     (div_dvs_reg),
        .done        (div_done),
        .quotient    (div_quo),
        .rem_nonzero (div_rem_nz)
    );

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // |num| fits 31 bits: num lies strictly within +/-2^31
    assign num_mag = num_reg[gdet_pkg::NUM_W-1] ? gdet_pkg::DVS_W'(-num_reg)
                                                : gdet_pkg::DVS_W'(num_reg);
    // negative side rounds magnitude up, i.e. floor of the signed value
    assign neg_q = {1'b0, div_quo[gdet_pkg::CX_W-1:0]} + (gdet_pkg::CX_W+1)'(div_rem_nz);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cx_reg, out_ratio_reg, out_detect_reg, out_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_tready && state_reg != ST_OUT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_job;
                        state_reg <= ST_AREA;
                    end
                end
                ST_AREA: begin
                    area_reg  <= gdet_pkg::AREA_W'(job_reg.width)
                               * gdet_pkg::AREA_W'(job_reg.height);
                    state_reg <= ST_PROD;
                end
                ST_PROD: begin
                    den_reg   <= gdet_pkg::DEN_W'(job_reg.width)
                               * gdet_pkg::DEN_W'(job_reg.count);
                    c50_reg   <= gdet_pkg::C50_W'(job_reg.count)
                               * gdet_pkg::C50_W'(gdet_pkg::DETECT_FACTOR);
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    num_reg <= $signed({1'b0, job_reg.sum, 1'b0})
                             - $signed({1'b0, den_reg});
                    state_reg <= ST_RATIO;
                end
                ST_RATIO: begin
                    div_dvd_reg   <= {{(gdet_pkg::DVD_W-gdet_pkg::CNT_W-16){1'b0}},
                                      job_reg.count, 16'd0};
                    div_dvs_reg   <= {{(gdet_pkg::DVS_W-gdet_pkg::AREA_W){1'b0}}, area_reg};
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_RATIO_WAIT;
                end
                ST_RATIO_WAIT: begin
                    if (div_done) begin
                        ratio_reg <= (div_quo > gdet_pkg::DVD_W'(gdet_pkg::RATIO_ONE))
                                   ? gdet_pkg::RATIO_ONE : div_quo[gdet_pkg::RATIO_W-1:0];
                        state_reg <= ST_CX;
                    end
                end
                ST_CX: begin
                    if (job_reg.count == '0) begin
                        cx_reg    <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        div_dvd_reg   <= {1'b0, num_mag, 15'd0};
                        div_dvs_reg   <= den_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_CX_WAIT;
                    end
                end
                ST_CX_WAIT: begin
                    if (div_done) begin
                        if (!num_reg[gdet_pkg::NUM_W-1]) begin
                            cx_reg <= (div_quo > gdet_pkg::DVD_W'(32767))
                                    ? gdet_pkg::CX_W'(32767) : div_quo[gdet_pkg::CX_W-1:0];
                        end else if (div_quo >= gdet_pkg::DVD_W'(32768)) begin
                            cx_reg <= gdet_pkg::CX_W'(32768);
                        end else begin
                            cx_reg <= gdet_pkg::CX_W'(-neg_q);
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg  <= 1'b1;
                        out_count_reg  <= job_reg.count;
                        out_detect_reg <= c50_reg > gdet_pkg::C50_W'(area_reg);
                        out_ratio_reg  <= ratio_reg;
                        out_cx_reg     <= cx_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/green_blob_detector_core.sv -----
// Top level of the green blob detector: config registers, front, queue and back.
//
// Pixels (red, green, blue) stream in raster order at up to one word per clock;
// the block tracks column and row from frame_width/frame_height (clamped to
// 1..1024). A pixel is green when green > red + margin, green > blue + margin
// and green > min_green. After the last pixel of a frame one result word
// leaves: green_count, detected (count*50 > area), green_ratio (Q1.16, 65536
// is the whole frame) and centroid_x (Q1.15, floored, saturated, 0 when no
// pixel is green). The front takes one pixel per clock while the four-deep
// job queue has room and hands each finished frame to it; the back works
// through a job in order: a pop, the area, product and numerator steps
// (multiply/subtract), then up to two passes of one shared bit-serial divider
// (ratio, then centroid, skipped when no pixel is green), then the output
// register. Frames stream at one pixel per clock with no stall as long as
// results are taken promptly and the queue has room; s_tready drops only while
// the job queue is full, which takes frames that end faster than the back end
// drains them, or a result side held off. Configuration writes are always taken
// (cfg_ready is tied high) and are meant to land between frames.
module green_blob_detector_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // pixel input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gdet_pkg::IN_DATA_W-1:0]   s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // frame results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gdet_pkg::OUT_DATA_W-1:0]  m_tdata,   // green_count[20:0], detected[21],
                                                        // green_ratio[38:22], centroid_x[54:39]
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gdet_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gdet_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [gdet_pkg::DIM_W-1:0] frame_width_reg;
    logic [gdet_pkg::DIM_W-1:0] frame_height_reg;
    logic [gdet_pkg::PIX_W-1:0] margin_reg;
    logic [gdet_pkg::PIX_W-1:0] min_green_reg;

    gdet_pkg::cfg_t cfg;
    gdet_pkg::job_t push_job, pop_job;
    logic           q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= gdet_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= gdet_pkg::RST_FRAME_HEIGHT;
            margin_reg       <= gdet_pkg::RST_MARGIN;
            min_green_reg    <= gdet_pkg::RST_MIN_GREEN;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gdet_pkg::REG_FRAME_WIDTH:      frame_width_reg  <= cfg_data;
                gdet_pkg::REG_FRAME_HEIGHT:     frame_height_reg <= cfg_data;
                gdet_pkg::REG_DOMINANCE_MARGIN: margin_reg       <= cfg_data[7:0];
                gdet_pkg::REG_MIN_GREEN:        min_green_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective frame size, clamped to 1..max
    always_comb begin
        if (frame_width_reg == '0) begin
            cfg.width = gdet_pkg::DIM_W'(1);
        end else if (frame_width_reg > gdet_pkg::DIM_W'(gdet_pkg::MAX_WIDTH)) begin
            cfg.width = gdet_pkg::DIM_W'(gdet_pkg::MAX_WIDTH);
        end else begin
            cfg.width = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            cfg.height = gdet_pkg::DIM_W'(1);
        end else if (frame_height_reg > gdet_pkg::DIM_W'(gdet_pkg::MAX_HEIGHT)) begin
            cfg.height = gdet_pkg::DIM_W'(gdet_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = frame_height_reg;
        end
        cfg.margin    = margin_reg;
        cfg.min_green = min_green_reg;
    end

    gdet_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    gdet_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    gdet_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- design/gdet_checker.sv -----
// Port-level checks on the green blob detector and their bind.
module gdet_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gdet_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // ratio never exceeds one
    a_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:22] <= gdet_pkg::RATIO_ONE)
        else $error("green ratio above one");

    // empty frame gives an all-zero result
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:0] == '0 |-> m_tdata[54:21] == '0)
        else $error("non-zero statistics for a frame with no green pixel");

    // detection needs green pixels and a non-zero ratio
    a_detect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[21] |-> m_tdata[20:0] != '0 && m_tdata[38:22] != '0)
        else $error("detect flag without green pixels");

endmodule

bind green_blob_detector_core gdet_checker u_gdet_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/green_blob_detector_core_chk.sv -----
// Stream monitor, frame statistics predictor and result scoreboard for the detector.
`timescale 1ns / 100ps
module green_blob_detector_core_chk (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [gdet_pkg::IN_DATA_W-1:0]   s_tdata,   // red, green, blue
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [gdet_pkg::OUT_DATA_W-1:0]  m_tdata,   // count, detected, ratio, centroid
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [gdet_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gdet_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               frames_pending,
    output int                               frames_checked
);

    localparam int DET_BIT   = gdet_pkg::CNT_W;
    localparam int RATIO_LSB = gdet_pkg::CNT_W + 1;
    localparam int CX_LSB    = gdet_pkg::CNT_W + 1 + gdet_pkg::RATIO_W;

    typedef struct packed {
        logic [gdet_pkg::CNT_W-1:0]   count;
        logic                         detected;
        logic [gdet_pkg::RATIO_W-1:0] ratio;
        logic [gdet_pkg::CX_W-1:0]    centroid;
    } frame_stats_t;

    frame_stats_t frame_stats_q[$];

    logic [gdet_pkg::DIM_W-1:0] width_reg;
    logic [gdet_pkg::DIM_W-1:0] height_reg;
    logic [gdet_pkg::PIX_W-1:0] margin_reg;
    logic [gdet_pkg::PIX_W-1:0] min_green_reg;
    int unsigned                col_pos;
    int unsigned                row_pos;
    logic [gdet_pkg::CNT_W-1:0] green_total;
    logic [gdet_pkg::SUM_W-1:0] col_sum;
    int                         fails = 0;
    int                         checked = 0;

    function automatic int unsigned clamp_dim(input logic [gdet_pkg::DIM_W-1:0] v,
                                              input int unsigned lim);
        if (v == '0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Accumulate one pixel; on the last pixel of a frame work out its statistics
    task automatic tally_pixel(input logic [gdet_pkg::IN_DATA_W-1:0] word);
        int unsigned  red, grn, blu, eff_w, eff_h;
        longint       cnt, sum, area, ratio, num, den, cx;
        frame_stats_t res;
        red   = word[7:0];
        grn   = word[15:8];
        blu   = word[23:16];
        eff_w = clamp_dim(width_reg, gdet_pkg::MAX_WIDTH);
        eff_h = clamp_dim(height_reg, gdet_pkg::MAX_HEIGHT);
        // exact compares, no 8-bit wrap of red + margin
        if (grn > red + margin_reg && grn > blu + margin_reg && grn > min_green_reg) begin
            green_total = green_total + 1'b1;
            col_sum     = col_sum + gdet_pkg::SUM_W'(col_pos);
        end
        if (col_pos < eff_w - 1) begin
            col_pos++;
        end else begin
            col_pos = 0;
            if (row_pos < eff_h - 1) begin
                row_pos++;
            end else begin
                row_pos     = 0;
                area        = longint'(eff_w) * longint'(eff_h);
                cnt         = green_total;
                sum         = col_sum;
                green_total = '0;
                col_sum     = '0;
                ratio       = (cnt << 16) / area;
                if (ratio > 65536)
                    ratio = 65536;
                cx = 0;
                if (cnt != 0) begin
                    num = 2 * sum - longint'(eff_w) * cnt;
                    den = longint'(eff_w) * cnt;
                    // floor division, also for a left-of-centre mean
                    if (num >= 0)
                        cx = (num * 32768) / den;
                    else
                        cx = -(((-num) * 32768 + den - 1) / den);
                    if (cx > 32767)
                        cx = 32767;
                    if (cx < -32768)
                        cx = -32768;
                end
                res.count    = cnt[gdet_pkg::CNT_W-1:0];
                res.detected = (cnt * 50 > area);
                res.ratio    = ratio[gdet_pkg::RATIO_W-1:0];
                res.centroid = cx[gdet_pkg::CX_W-1:0];
                frame_stats_q = {frame_stats_q, res};
            end
        end
    endtask

    task automatic check_result(input logic [gdet_pkg::OUT_DATA_W-1:0] word);
        frame_stats_t want;
        if (frame_stats_q.size() == 0) begin
            $error("result word with no frame outstanding: %h", word);
            fails++;
        end else begin
            want = frame_stats_q.pop_front();
            checked++;
            if (word[gdet_pkg::CNT_W-1:0] !== want.count) begin
                $error("green_count mismatch: expected %0d, got %0d",
                       want.count, word[gdet_pkg::CNT_W-1:0]);
                fails++;
            end
            if (word[DET_BIT] !== want.detected) begin
                $error("detected mismatch: expected %0d, got %0d", want.detected, word[DET_BIT]);
                fails++;
            end
            if (word[RATIO_LSB +: gdet_pkg::RATIO_W] !== want.ratio) begin
                $error("green_ratio mismatch: expected %0d, got %0d",
                       want.ratio, word[RATIO_LSB +: gdet_pkg::RATIO_W]);
                fails++;
            end
            if (word[CX_LSB +: gdet_pkg::CX_W] !== want.centroid) begin
                $error("centroid_x mismatch: expected %0d, got %0d",
                       $signed(want.centroid), $signed(word[CX_LSB +: gdet_pkg::CX_W]));
                fails++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     = gdet_pkg::RST_FRAME_WIDTH;
            height_reg    = gdet_pkg::RST_FRAME_HEIGHT;
            margin_reg    = gdet_pkg::RST_MARGIN;
            min_green_reg = gdet_pkg::RST_MIN_GREEN;
            col_pos       = 0;
            row_pos       = 0;
            green_total   = '0;
            col_sum       = '0;
            frame_stats_q.delete();
        end else begin
            // a result always belongs to an older frame than a pixel taken this edge
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            // a pixel taken on the same edge as a register write still sees the old value
            if (s_tvalid && s_tready)
                tally_pixel(s_tdata);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gdet_pkg::REG_FRAME_WIDTH:
                        width_reg     = cfg_data[gdet_pkg::DIM_W-1:0];
                    gdet_pkg::REG_FRAME_HEIGHT:
                        height_reg    = cfg_data[gdet_pkg::DIM_W-1:0];
                    gdet_pkg::REG_DOMINANCE_MARGIN:
                        margin_reg    = cfg_data[gdet_pkg::PIX_W-1:0];
                    gdet_pkg::REG_MIN_GREEN:
                        min_green_reg = cfg_data[gdet_pkg::PIX_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count     <= fails;
        frames_pending <= frame_stats_q.size();
        frames_checked <= checked;
    end

endmodule

// ----- dv/green_blob_detector_core_tb.sv -----
// Testbench top for the green blob detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module green_blob_detector_core_tb;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_PIXELS = 400;
    // back end works through one job at a time from a four-deep queue; allow plenty
    localparam int QUIET_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [gdet_pkg::IN_DATA_W-1:0]  s_tdata   = '0;   // red[7:0], green[15:8], blue[23:16]
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [gdet_pkg::OUT_DATA_W-1:0] m_tdata;          // count[20:0], detected[21],
                                                       // ratio[38:22], centroid_x[54:39]
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gdet_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gdet_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int frames_pending;
    int frames_checked;

    int send_idle_pct  = 16;
    int recv_stall_pct = 70;
    int cycles         = 0;
    int pixels_sent    = 0;
    int settings_used  = 0;
    int cur_margin     = gdet_pkg::RST_MARGIN;
    int cur_min        = gdet_pkg::RST_MIN_GREEN;

    green_blob_detector_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    green_blob_detector_core_chk u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Result side back-pressure, redrawn every clock
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: a lost result or a hung handshake ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [gdet_pkg::IN_DATA_W-1:0] rgb(input int r, input int g, input int b);
        return {8'(b), 8'(g), 8'(r)};
    endfunction

    function automatic int clip8(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // Mix of plain noise, green-leaning pixels and pixels sat on the thresholds
    function automatic logic [gdet_pkg::IN_DATA_W-1:0] random_pixel();
        int g, r, b;
        g = $urandom_range(255);
        r = $urandom_range(g);
        b = $urandom_range(g);
        case ($urandom_range(9))
            0, 1, 2: return rgb($urandom_range(255), $urandom_range(255), $urandom_range(255));
            3: return rgb(clip8(g - cur_margin - 1 + $urandom_range(2)), g, b);
            4: return rgb(r, g, clip8(g - cur_margin - 1 + $urandom_range(2)));
            5: return rgb(r, clip8(cur_min - 1 + $urandom_range(2)), b);
            default: return rgb(r, g, b);
        endcase
    endfunction

    // Present one word; valid stays high into the next word unless a gap is drawn
    task automatic push_pixel(input logic [gdet_pkg::IN_DATA_W-1:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    // Hold off until every outstanding frame result is back, then let the back end settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frames_pending != 0);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [gdet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gdet_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Full register set; now and then a write to an unmapped index too
    task automatic apply_setting(input logic [gdet_pkg::CFG_DATA_W-1:0] w,
                                 input logic [gdet_pkg::CFG_DATA_W-1:0] h,
                                 input logic [gdet_pkg::CFG_DATA_W-1:0] margin,
                                 input logic [gdet_pkg::CFG_DATA_W-1:0] floor_g);
        write_reg(gdet_pkg::REG_FRAME_WIDTH, w);
        write_reg(gdet_pkg::REG_FRAME_HEIGHT, h);
        write_reg(gdet_pkg::REG_DOMINANCE_MARGIN, margin);
        write_reg(gdet_pkg::REG_MIN_GREEN, floor_g);
        if ($urandom_range(3) == 0)
            write_reg(gdet_pkg::CFG_IDX_W'(gdet_pkg::REG_MIN_GREEN + 1 + $urandom_range(251)),
                      gdet_pkg::CFG_DATA_W'($urandom_range(2047)));
        cfg_valid <= 1'b0;
        cur_margin = margin[gdet_pkg::PIX_W-1:0];
        cur_min    = floor_g[gdet_pkg::PIX_W-1:0];
        settings_used++;
    endtask

    initial begin
        int rand_base, stage, w, h, eff_area, n_pix, n_left;
        logic [gdet_pkg::CFG_DATA_W-1:0] m_val, g_val;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed: threshold edges under the reset margin (40) and floor (80) ---
        write_reg(gdet_pkg::REG_FRAME_WIDTH, 8);
        write_reg(gdet_pkg::REG_FRAME_HEIGHT, 3);
        cfg_valid <= 1'b0;
        push_pixel(rgb(50, 91, 0));     // just over red + margin
        push_pixel(rgb(50, 90, 0));     // exactly red + margin: not green
        push_pixel(rgb(0, 120, 80));    // exactly blue + margin: not green
        push_pixel(rgb(0, 80, 0));      // at the floor: not green
        push_pixel(rgb(0, 81, 0));      // just over the floor
        push_pixel(rgb(255, 255, 255));
        push_pixel(rgb(0, 0, 0));
        push_pixel(rgb(0, 255, 0));
        push_pixel(rgb(255, 255, 0));   // red + margin above 255, must not wrap
        push_pixel(rgb(214, 255, 0));
        repeat (14) push_pixel(random_pixel());
        drain();

        // zero width clamps to 1 and height is 1: every pixel is a frame of its own
        apply_setting(0, 1, 0, 0);
        push_pixel(rgb(0, 255, 0));     // single green pixel at column 0: centroid fully left
        push_pixel(rgb(0, 0, 0));       // no green pixel: all-zero result
        push_pixel(rgb(255, 255, 255));
        drain();

        // over-range width: a long row must not end early; a resize then closes it
        apply_setting(2047, 1, 0, 0);
        repeat (40) push_pixel(random_pixel());
        drain();
        apply_setting(8, 1, 0, 0);
        push_pixel(random_pixel());
        drain();

        // over-range height, one pixel a row; margin write carries junk above
        // bit 7, only the low byte counts; a resize then closes the frame
        apply_setting(1, 2047, 11'h503, 254);
        repeat (40) push_pixel(rgb(0, 255, 0));
        drain();
        write_reg(gdet_pkg::REG_FRAME_HEIGHT, 2);
        cfg_valid <= 1'b0;
        push_pixel(rgb(0, 255, 0));
        drain();

        // largest margin and floor: nothing can qualify
        apply_setting(2, 2, 255, 255);
        repeat (4) push_pixel(rgb(0, 255, 0));
        drain();
        write_reg(gdet_pkg::CFG_IDX_W'(gdet_pkg::REG_MIN_GREEN + 1), 11'h7FF);
        cfg_valid <= 1'b0;

        // width shrinks below the current column mid-frame: row must end at once
        apply_setting(8, 4, 20, 60);
        repeat (13) push_pixel(random_pixel());
        drain();
        apply_setting(3, 4, 20, 60);
        repeat (6) push_pixel(random_pixel());
        drain();

        // height shrinks below the current row mid-frame: frame must end at once
        apply_setting(4, 6, 10, 30);
        repeat (16) push_pixel(random_pixel());
        drain();
        apply_setting(4, 2, 10, 30);
        repeat (9) push_pixel(random_pixel());
        drain();

        // --- random: mostly whole small frames, some cut short before a resize ---
        rand_base = pixels_sent;
        while (pixels_sent - rand_base < RANDOM_PIXELS) begin
            stage = (pixels_sent - rand_base) * 3 / RANDOM_PIXELS;
            case (stage)
                0: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 70;
                end
                1: begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 16;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case ($urandom_range(9))
                0:       w = 0;
                1:       w = $urandom_range(9, 24);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(9))
                0:       h = 0;
                1:       h = $urandom_range(6, 12);
                default: h = $urandom_range(1, 5);
            endcase
            case ($urandom_range(5))
                0:       m_val = 0;
                1:       m_val = 255;
                default: m_val = gdet_pkg::CFG_DATA_W'($urandom_range(2047));
            endcase
            case ($urandom_range(5))
                0:       g_val = 0;
                1:       g_val = 255;
                default: g_val = gdet_pkg::CFG_DATA_W'($urandom_range(2047));
            endcase
            apply_setting(gdet_pkg::CFG_DATA_W'(w), gdet_pkg::CFG_DATA_W'(h), m_val, g_val);
            eff_area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            n_pix    = eff_area * $urandom_range(1, 3);
            if ($urandom_range(4) == 0)
                n_pix += $urandom_range(1, eff_area);
            // keep the total close to the planned pixel budget
            n_left = RANDOM_PIXELS - (pixels_sent - rand_base);
            if (n_pix > n_left)
                n_pix = n_left;
            repeat (n_pix) push_pixel(random_pixel());
            drain();
        end

        $display("Streamed %0d pixels through %0d register settings, %0d frame results checked",
                 pixels_sent, settings_used, frames_checked);
        $display("Threshold edges, clamped sizes, mid-frame resizes and both stall patterns hit");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
